@@ rtl/calclk_pkg.sv @@
// calendar clock package: item types, command codes and calendar tables
// used by the calendar clock top level and its port checker; no dependencies
package calclk_pkg;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdSet     = 2'd1,
    CmdConvert = 2'd2,
    CmdDay     = 2'd3
  } cmd_e;

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned MinLimit    = 60;
  localparam int unsigned HourLimit   = 24;
  localparam int unsigned MonthLimit  = 13;

  // stages holding an item: input, clock update, day count, result
  localparam int unsigned PipeDepth   = 4;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_t;

  typedef struct packed {
    cmd_e        command;
    logic [11:0] stamp_year;
    logic [3:0]  stamp_month;
    logic [4:0]  stamp_day;
    logic [4:0]  stamp_hour;
    logic [5:0]  stamp_minute;
    logic [5:0]  stamp_second;
  } in_t;

  typedef struct packed {
    logic [11:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [31:0] epoch_seconds;
  } out_t;

  // month 0 counts as january, 13 to 15 as december
  function automatic logic [4:0] month_len(input logic [11:0] year, input logic [3:0] month);
    logic [4:0] len;
    case (month) inside
      4'd2:                     len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // days of the common year before the month
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      default:    days = 9'd334;
    endcase
    return days;
  endfunction

endpackage

@@ rtl/calendar_clock_with_epoch_seconds.sv @@
// calendar clock with epoch seconds: top level, four-register pipeline
// depends on calclk_pkg for item types, command codes and month tables
//
// Use: one input channel (in_valid_i / in_ready_o / in_data_i) takes an item
// holding a command and a stamp; one output channel (out_valid_o /
// out_ready_i / out_data_o) returns exactly one result item per input item,
// in order. Tick moves the clock on one second, set loads the stamp, day
// advance adds one day, convert reports the stamp's seconds since 1 Jan
// EPOCH_YEAR and leaves the clock alone. Every result carries the clock after
// the step and an epoch-seconds value.
// Throughput: one item per cycle unless out_ready_i stalls the output; the
// pipeline is input register, clock update, day count and time of day, then
// the 32-bit multiply by 86400 into the result register. The clock registers
// change as an item leaves the first stage, so back-to-back items see each
// other's updates in order.
// Reset: clock returns to 2024-01-01 00:00:00 and the pipeline empties.
// Stall: a held result freezes the last stage; earlier stages keep filling,
// so up to four items are held before in_ready_o drops.
module calendar_clock_with_epoch_seconds #(
  parameter int unsigned EPOCH_YEAR = 2024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  calclk_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output calclk_pkg::out_t  out_data_o
);
  import calclk_pkg::*;

  localparam logic [31:0] EpochYear = 32'(EPOCH_YEAR);
  localparam logic [31:0] LeapBase  = 32'((EPOCH_YEAR + 3) / 4);

  // pipeline registers
  logic        s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  in_t         s1_q;
  stamp_t      s2_now_q, s2_src_q, s3_now_q;
  logic [31:0] s3_days_q;
  logic [16:0] s3_tod_q;
  out_t        out_q;
  stamp_t      clock_q, clock_d;

  // each stage moves when the one after it is empty or moving
  logic out_free, s3_free, s2_free, s1_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s3_free    = !s3_valid_q || out_free;
  assign s2_free    = !s2_valid_q || s3_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;

  logic s1_move;
  assign s1_move = s1_valid_q && s2_free;

  // clock update for the item in the first stage
  logic [6:0]  sec_inc, min_inc;
  logic [5:0]  hour_inc, day_inc, day_limit;
  logic [4:0]  month_inc;
  logic        sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap, adv_day;

  assign sec_inc    = {1'b0, clock_q.second} + 7'd1;
  assign min_inc    = {1'b0, clock_q.minute} + 7'd1;
  assign hour_inc   = {1'b0, clock_q.hour} + 6'd1;
  assign day_inc    = {1'b0, clock_q.day} + 6'd1;
  assign month_inc  = {1'b0, clock_q.month} + 5'd1;
  assign day_limit  = {1'b0, month_len(clock_q.year, clock_q.month)} + 6'd1;
  assign sec_wrap   = sec_inc >= 7'(MinLimit);
  assign min_wrap   = min_inc >= 7'(MinLimit);
  assign hour_wrap  = hour_inc >= 6'(HourLimit);
  assign day_wrap   = day_inc >= day_limit;
  assign month_wrap = month_inc >= 5'(MonthLimit);
  assign adv_day    = (s1_q.command == CmdDay) ||
                      ((s1_q.command == CmdTick) && sec_wrap && min_wrap && hour_wrap);

  always_comb begin
    clock_d = clock_q;
    case (s1_q.command)
      CmdTick: begin
        clock_d.second = sec_wrap ? 6'd0 : sec_inc[5:0];
        if (sec_wrap) begin
          clock_d.minute = min_wrap ? 6'd0 : min_inc[5:0];
        end
        if (sec_wrap && min_wrap) begin
          clock_d.hour = hour_wrap ? 5'd0 : hour_inc[4:0];
        end
      end
      CmdSet: begin
        clock_d.year   = s1_q.stamp_year;
        clock_d.month  = s1_q.stamp_month;
        clock_d.day    = s1_q.stamp_day;
        clock_d.hour   = s1_q.stamp_hour;
        clock_d.minute = s1_q.stamp_minute;
        clock_d.second = s1_q.stamp_second;
      end
      default: ;
    endcase
    if (adv_day) begin
      clock_d.day = day_wrap ? 5'd1 : day_inc[4:0];
      if (day_wrap) begin
        clock_d.month = month_wrap ? 4'd1 : month_inc[3:0];
        if (month_wrap) begin
          clock_d.year = clock_q.year + 12'd1;
        end
      end
    end
  end

  stamp_t s1_stamp;
  assign s1_stamp = '{year: s1_q.stamp_year, month: s1_q.stamp_month, day: s1_q.stamp_day,
                      hour: s1_q.stamp_hour, minute: s1_q.stamp_minute,
                      second: s1_q.stamp_second};

  // day count and time of day of the selected stamp, all modulo 2^32
  logic [31:0] year_off, days_d;
  logic [10:0] leaps_upto;
  logic [12:0] year_p3;
  logic        leap_extra;
  logic [16:0] tod_d;

  assign year_off   = 32'(s2_src_q.year) - EpochYear;
  assign year_p3    = {1'b0, s2_src_q.year} + 13'd3;
  assign leaps_upto = year_p3[12:2];
  assign leap_extra = (s2_src_q.year[1:0] == 2'b00) && (s2_src_q.month >= 4'd3);
  assign days_d     = year_off * 32'(DaysPerYear) + (32'(leaps_upto) - LeapBase)
                    + 32'(days_before(s2_src_q.month)) + 32'(leap_extra)
                    + 32'(s2_src_q.day) - 32'd1;
  assign tod_d      = 17'(s2_src_q.hour) * 17'(SecsPerHour)
                    + 17'(s2_src_q.minute) * 17'(SecsPerMin) + 17'(s2_src_q.second);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      clock_q     <= '{year: 12'd2024, month: 4'd1, day: 5'd1,
                       hour: 5'd0, minute: 6'd0, second: 6'd0};
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_free) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s3_valid_q;
      end
      if (s1_move) begin
        clock_q <= clock_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (s1_move) begin
      s2_now_q <= clock_d;
      s2_src_q <= (s1_q.command == CmdConvert) ? s1_stamp : clock_d;
    end
    if (s3_free && s2_valid_q) begin
      s3_now_q  <= s2_now_q;
      s3_days_q <= days_d;
      s3_tod_q  <= tod_d;
    end
    if (out_free && s3_valid_q) begin
      out_q.now_year      <= s3_now_q.year;
      out_q.now_month     <= s3_now_q.month;
      out_q.now_day       <= s3_now_q.day;
      out_q.now_hour      <= s3_now_q.hour;
      out_q.now_minute    <= s3_now_q.minute;
      out_q.now_second    <= s3_now_q.second;
      out_q.epoch_seconds <= s3_days_q * 32'(SecsPerDay) + 32'(s3_tod_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/calclk_checker.sv @@
// port checker for the calendar clock, bound to the top level
// depends on calclk_pkg for the result item type and the pipeline depth
module calclk_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input calclk_pkg::out_t out_data_o
);
  import calclk_pkg::*;

  // items taken but not yet delivered
  logic [2:0] held_q, held_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign held_d  = held_q + 3'(in_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 3'd0;
    end else begin
      held_q <= held_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result item changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> held_q != 3'd0)
    else $error("result item offered with no item outstanding");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> held_q == 3'(PipeDepth))
    else $error("input stalled while the pipeline has room");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= 3'(PipeDepth))
    else $error("more items outstanding than pipeline stages");

endmodule

bind calendar_clock_with_epoch_seconds calclk_checker u_calclk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

@@ tb/sv/testbench.sv @@
// testbench for the calendar clock with epoch seconds: directed calendar corners
// then bursty random traffic, checked against an in-bench calendar predictor
// depends on calclk_pkg and calendar_clock_with_epoch_seconds
`timescale 1ns / 100ps

module testbench;
  import calclk_pkg::*;

  localparam int unsigned EpochBase = 2024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  calendar_clock_with_epoch_seconds #(
    .EPOCH_YEAR(EpochBase)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #2 clk_i = ~clk_i;

  // predicted clock and the results still owed by the block
  stamp_t wall;
  out_t   owed_results[$];

  int unsigned month_len_tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_ahead_tab[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  int mismatch_count = 0;
  int stray_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cmd_count[4] = '{0, 0, 0, 0};

  bit tx_gaps_on = 1'b0;
  bit rx_stall_on = 1'b0;
  int burst_left = 8;
  logic [15:0] rx_mask = 16'hffff;
  int rx_pos = 0;

  // month 0 reads as january, 13 and above as december
  function automatic int unsigned month_slot(logic [3:0] month);
    if (month < 4'd1) return 0;
    if (month > 4'd12) return 11;
    return month - 1;
  endfunction

  function automatic int unsigned days_in_month(logic [11:0] year, logic [3:0] month);
    int unsigned idx;
    idx = month_slot(month);
    if (idx == 1 && year[1:0] == 2'b00) return 29;
    return month_len_tab[idx];
  endfunction

  function automatic logic [31:0] secs_since_epoch(logic [11:0] y, logic [3:0] mo,
                                                   logic [4:0] d, logic [4:0] h,
                                                   logic [5:0] mi, logic [5:0] s);
    logic [31:0] yy;
    logic [31:0] days;
    int unsigned idx;
    yy = {20'd0, y};
    idx = month_slot(mo);
    days = 32'd365 * (yy - EpochBase);
    days = days + (yy + 32'd3) / 32'd4 - (EpochBase + 32'd3) / 32'd4;
    days = days + days_ahead_tab[idx];
    if (idx >= 2 && y[1:0] == 2'b00) days = days + 32'd1;
    days = days + {27'd0, d} - 32'd1;
    return days * 32'd86400 + {27'd0, h} * 32'd3600 + {26'd0, mi} * 32'd60 + {26'd0, s};
  endfunction

  function automatic void roll_day();
    int unsigned lim;
    int unsigned nd;
    int unsigned nm;
    lim = days_in_month(wall.year, wall.month) + 1;
    nd = wall.day + 1;
    if (nd >= lim) begin
      nm = wall.month + 1;
      nd = 1;
      if (nm >= 13) begin
        nm = 1;
        wall.year = wall.year + 12'd1;
      end
      wall.month = nm[3:0];
    end
    wall.day = nd[4:0];
  endfunction

  function automatic void roll_second();
    int unsigned ns;
    int unsigned nm;
    int unsigned nh;
    ns = wall.second + 1;
    if (ns >= 60) begin
      ns = 0;
      nm = wall.minute + 1;
      if (nm >= 60) begin
        nm = 0;
        nh = wall.hour + 1;
        if (nh >= 24) begin
          nh = 0;
          roll_day();
        end
        wall.hour = nh[4:0];
      end
      wall.minute = nm[5:0];
    end
    wall.second = ns[5:0];
  endfunction

  function automatic out_t step_clock(in_t it);
    out_t res;
    case (it.command)
      CmdTick: roll_second();
      CmdDay:  roll_day();
      CmdSet: begin
        wall.year   = it.stamp_year;
        wall.month  = it.stamp_month;
        wall.day    = it.stamp_day;
        wall.hour   = it.stamp_hour;
        wall.minute = it.stamp_minute;
        wall.second = it.stamp_second;
      end
      default: ;
    endcase
    res.now_year   = wall.year;
    res.now_month  = wall.month;
    res.now_day    = wall.day;
    res.now_hour   = wall.hour;
    res.now_minute = wall.minute;
    res.now_second = wall.second;
    if (it.command == CmdConvert)
      res.epoch_seconds = secs_since_epoch(it.stamp_year, it.stamp_month, it.stamp_day,
                                           it.stamp_hour, it.stamp_minute, it.stamp_second);
    else
      res.epoch_seconds = secs_since_epoch(wall.year, wall.month, wall.day,
                                           wall.hour, wall.minute, wall.second);
    return res;
  endfunction

  // holds valid until the item is taken, then maybe drops it for a gap
  task automatic send_item(in_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_ready !== 1'b1) @(posedge clk_i);
    owed_results.push_back(step_clock(it));
    items_sent++;
    cmd_count[it.command]++;
    if (tx_gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  function automatic in_t make_item(cmd_e cmd, int unsigned y, int unsigned mo, int unsigned d,
                                    int unsigned h, int unsigned mi, int unsigned s);
    in_t it;
    it.command      = cmd;
    it.stamp_year   = y[11:0];
    it.stamp_month  = mo[3:0];
    it.stamp_day    = d[4:0];
    it.stamp_hour   = h[4:0];
    it.stamp_minute = mi[5:0];
    it.stamp_second = s[5:0];
    return it;
  endfunction

  // a legal stamp, often sitting just short of a carry
  function automatic in_t near_edge_stamp(cmd_e cmd);
    int unsigned y;
    int unsigned mo;
    int unsigned len;
    int unsigned d;
    y = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) != 0) ? 2099 : 2024)
                                     : $urandom_range(2024, 2099);
    mo = $urandom_range(1, 12);
    len = days_in_month(y[11:0], mo[3:0]);
    case ($urandom_range(0, 3))
      0:       d = len;
      1:       d = len - 1;
      2:       d = 1;
      default: d = $urandom_range(1, len);
    endcase
    return make_item(cmd, y, mo, d,
                     ($urandom_range(0, 2) != 0) ? 23 : $urandom_range(0, 23),
                     ($urandom_range(0, 2) != 0) ? 59 : $urandom_range(0, 59),
                     ($urandom_range(0, 2) != 0) ? $urandom_range(57, 59)
                                                 : $urandom_range(0, 59));
  endfunction

  function automatic in_t noise_item();
    in_t it;
    it.command      = cmd_e'($urandom_range(0, 3));
    it.stamp_year   = 12'($urandom());
    it.stamp_month  = 4'($urandom());
    it.stamp_day    = 5'($urandom());
    it.stamp_hour   = 5'($urandom());
    it.stamp_minute = 6'($urandom());
    it.stamp_second = 6'($urandom());
    return it;
  endfunction

  task automatic test_reset_state();
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdDay, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_calendar_rollover();
    // new year, leap february, common february, short month, top of the year field
    send_item(make_item(CmdSet, 2024, 12, 31, 23, 59, 59));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdSet, 2024, 2, 28, 23, 59, 59));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdSet, 2025, 2, 28, 23, 59, 59));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdSet, 2026, 4, 30, 13, 5, 7));
    send_item(make_item(CmdDay, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdSet, 4095, 12, 31, 23, 59, 59));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_convert_corners();
    send_item(make_item(CmdConvert, 2099, 12, 31, 23, 59, 59));
    send_item(make_item(CmdConvert, 2024, 1, 1, 0, 0, 0));
    // before the epoch, so the count wraps
    send_item(make_item(CmdConvert, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdConvert, 4095, 15, 31, 31, 63, 63));
    send_item(make_item(CmdConvert, 2028, 0, 0, 24, 60, 60));
  endtask

  task automatic test_unchecked_fields();
    // fields past their limits still carry on the next step
    send_item(make_item(CmdSet, 2031, 15, 31, 31, 63, 63));
    send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
    send_item(make_item(CmdSet, 2030, 0, 0, 12, 30, 30));
    send_item(make_item(CmdDay, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic(int n_items);
    int target;
    int run;
    int pick;
    target = items_sent + n_items;
    while (items_sent < target) begin
      // quiet stretch first, then both sides idling, then quiet again near the end
      tx_gaps_on  = (target - items_sent) < n_items - 250 && (target - items_sent) > 150;
      rx_stall_on = tx_gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(near_edge_stamp(CmdSet));
        run = $urandom_range(1, 8);
        repeat (run) begin
          case ($urandom_range(0, 9))
            0, 1:    send_item(make_item(CmdDay, 0, 0, 0, 0, 0, 0));
            2:       send_item(near_edge_stamp(CmdConvert));
            default: send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
          endcase
        end
      end else if (pick < 78) begin
        send_item(near_edge_stamp(CmdConvert));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 10)) send_item(noise_item());
        send_item(make_item(CmdTick, 0, 0, 0, 0, 0, 0));
      end else begin
        send_item(noise_item());
      end
    end
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
    end
  endtask

  // receiver: with stalls on, ready follows a random 16-bit mask, bit 0 always set; else ready stays high
  always @(posedge clk_i) begin
    if (!rx_stall_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= rx_mask[rx_pos];
      if (rx_pos == 15) begin
        rx_pos = 0;
        rx_mask = ($urandom_range(0, 1) != 0) ? (16'($urandom()) | 16'h0001)
                                              : (16'($urandom() | $urandom()) | 16'h0001);
      end else begin
        rx_pos = rx_pos + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= 10)
          $display("result %0d arrived with nothing outstanding", results_seen);
      end else begin
        want = owed_results.pop_front();
        compare_field("year", want.now_year, out_data.now_year);
        compare_field("month", want.now_month, out_data.now_month);
        compare_field("day", want.now_day, out_data.now_day);
        compare_field("hour", want.now_hour, out_data.now_hour);
        compare_field("minute", want.now_minute, out_data.now_minute);
        compare_field("second", want.now_second, out_data.now_second);
        compare_field("epoch_seconds", want.epoch_seconds, out_data.epoch_seconds);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int guard;
    wall = '{year: 12'd2024, month: 4'd1, day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_calendar_rollover();
    test_convert_corners();
    test_unchecked_fields();
    test_random_traffic(1950);
    in_valid <= 1'b0;
    guard = 0;
    while (owed_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (12) @(posedge clk_i);
    $display("sent %0d items (%0d ticks, %0d sets, %0d converts, %0d day steps), %0d results",
             items_sent, cmd_count[CmdTick], cmd_count[CmdSet], cmd_count[CmdConvert],
             cmd_count[CmdDay], results_seen);
    $display("%0d field mismatches, %0d stray results, %0d results never seen",
             mismatch_count, stray_count, owed_results.size());
    if (mismatch_count == 0 && stray_count == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/calclk_pkg.sv
rtl/calendar_clock_with_epoch_seconds.sv
rtl/calclk_checker.sv
tb/sv/testbench.sv
